@@ rtl/can_rmt_pkg.sv @@
// Shared types and constants for the CAN receive message table.
package can_rmt_pkg;

  localparam int TABLE_ENTRIES = 16;
  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

  localparam int KIND_W = 2;
  localparam int IDENT_W = 29;
  localparam int PAYLOAD_W = 64;
  localparam int SLOT_W = 4;
  localparam int SUB_W = 8;
  localparam int COUNT_W = 32;
  localparam int LIMIT_W = 5;

  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W = 29;

  localparam logic [IDENT_W-1:0] MUX_IDENT_RESET = 29'h180;

  typedef enum logic [KIND_W-1:0] {
    KIND_FRAME = 2'd0,
    KIND_LOAD  = 2'd1,
    KIND_READ  = 2'd2
  } kind_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_MUX_IDENT      = 1'b0,
    REG_ENTRIES_IN_USE = 1'b1
  } reg_index_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_LOAD,
    ST_READ_FETCH,
    ST_READ_DONE,
    ST_IGNORE
  } state_t;

  typedef enum logic [2:0] {
    RES_NONE,
    RES_FRAME,
    RES_LOAD,
    RES_READ,
    RES_ZERO
  } result_sel_t;

  typedef struct packed {
    logic        capture;
    logic        read_scan;
    logic        read_slot;
    logic        update;
    logic        load;
    result_sel_t result;
  } cmd_t;

  typedef struct packed {
    logic hit;
    logic scan_more;
  } status_t;

endpackage

@@ rtl/can_rmt_ctrl.sv @@
// Sequencer for the CAN receive message table: decodes requests and steps the search.
module can_rmt_ctrl (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [can_rmt_pkg::KIND_W-1:0]  kind,
  input  can_rmt_pkg::status_t            status,
  output can_rmt_pkg::cmd_t               cmd,
  output logic                            busy
);

  can_rmt_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= can_rmt_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      can_rmt_pkg::ST_IDLE: begin
        if (start) begin
          case (can_rmt_pkg::kind_t'(kind))
            can_rmt_pkg::KIND_FRAME: state_next = can_rmt_pkg::ST_SCAN;
            can_rmt_pkg::KIND_LOAD:  state_next = can_rmt_pkg::ST_LOAD;
            can_rmt_pkg::KIND_READ:  state_next = can_rmt_pkg::ST_READ_FETCH;
            default:                 state_next = can_rmt_pkg::ST_IGNORE;
          endcase
        end
      end
      can_rmt_pkg::ST_SCAN: begin
        if (status.hit || !status.scan_more) begin
          state_next = can_rmt_pkg::ST_IDLE;
        end
      end
      can_rmt_pkg::ST_READ_FETCH: state_next = can_rmt_pkg::ST_READ_DONE;
      can_rmt_pkg::ST_LOAD,
      can_rmt_pkg::ST_READ_DONE,
      can_rmt_pkg::ST_IGNORE:     state_next = can_rmt_pkg::ST_IDLE;
      default:                    state_next = can_rmt_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '{capture: 1'b0, read_scan: 1'b0, read_slot: 1'b0, update: 1'b0,
            load: 1'b0, result: can_rmt_pkg::RES_NONE};
    busy = 1'b1;
    case (state)
      can_rmt_pkg::ST_IDLE: begin
        busy = 1'b0;
        cmd.capture = start;
      end
      can_rmt_pkg::ST_SCAN: begin
        // Fetch the next entry while comparing the one fetched last cycle.
        cmd.read_scan = status.scan_more && !status.hit;
        cmd.update = status.hit;
        if (status.hit || !status.scan_more) begin
          cmd.result = can_rmt_pkg::RES_FRAME;
        end
      end
      can_rmt_pkg::ST_LOAD: begin
        cmd.load = 1'b1;
        cmd.result = can_rmt_pkg::RES_LOAD;
      end
      can_rmt_pkg::ST_READ_FETCH: cmd.read_slot = 1'b1;
      can_rmt_pkg::ST_READ_DONE:  cmd.result = can_rmt_pkg::RES_READ;
      can_rmt_pkg::ST_IGNORE:     cmd.result = can_rmt_pkg::RES_ZERO;
      default:                    busy = 1'b1;
    endcase
  end

endmodule

@@ rtl/can_rmt_dp.sv @@
// Datapath for the CAN receive message table: config registers, entry store, compare, results.
module can_rmt_dp (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_write,
  input  logic [can_rmt_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [can_rmt_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic [can_rmt_pkg::IDENT_W-1:0]      ident,
  input  logic                                 extended,
  input  logic [can_rmt_pkg::PAYLOAD_W-1:0]    payload,
  input  logic [can_rmt_pkg::SLOT_W-1:0]       slot,
  input  logic [can_rmt_pkg::SUB_W-1:0]        sub_register,
  input  can_rmt_pkg::cmd_t                    cmd,
  output can_rmt_pkg::status_t                 status,
  output logic                                 done,
  output logic                                 matched,
  output logic [can_rmt_pkg::SLOT_W-1:0]       match_slot,
  output logic [can_rmt_pkg::IDENT_W-1:0]      read_ident,
  output logic                                 read_extended,
  output logic [can_rmt_pkg::SUB_W-1:0]        read_sub_register,
  output logic [can_rmt_pkg::PAYLOAD_W-1:0]    read_payload,
  output logic                                 read_fresh,
  output logic [can_rmt_pkg::COUNT_W-1:0]      read_count
);

  localparam int N = can_rmt_pkg::TABLE_ENTRIES;

  logic [can_rmt_pkg::IDENT_W-1:0]   mux_ident;
  logic [can_rmt_pkg::LIMIT_W-1:0]   entries_in_use;

  logic [can_rmt_pkg::IDENT_W-1:0]   item_ident;
  logic                              item_ext;
  logic [can_rmt_pkg::PAYLOAD_W-1:0] item_payload;
  logic [can_rmt_pkg::SLOT_W-1:0]    item_slot;
  logic [can_rmt_pkg::SUB_W-1:0]     item_sub;

  logic [can_rmt_pkg::CNT_W-1:0]     scan_idx;
  logic [can_rmt_pkg::IDX_W-1:0]     cmp_idx;
  logic                              cmp_valid;

  logic [can_rmt_pkg::IDENT_W-1:0]   mem_ident   [N];
  logic                              mem_type    [N];
  logic [can_rmt_pkg::SUB_W-1:0]     mem_sub     [N];
  logic [can_rmt_pkg::PAYLOAD_W-1:0] mem_payload [N];
  logic [can_rmt_pkg::COUNT_W-1:0]   mem_count   [N];
  logic [N-1:0]                      valid;
  logic [N-1:0]                      fresh;

  logic [can_rmt_pkg::IDENT_W-1:0]   rd_ident;
  logic                              rd_type;
  logic [can_rmt_pkg::SUB_W-1:0]     rd_sub;
  logic [can_rmt_pkg::PAYLOAD_W-1:0] rd_payload;
  logic [can_rmt_pkg::COUNT_W-1:0]   rd_count;

  logic [can_rmt_pkg::CNT_W-1:0]     limit;
  logic [can_rmt_pkg::IDX_W-1:0]     item_idx;
  logic                              slot_ok;
  logic                              load_en;
  logic                              wr_en;
  logic [can_rmt_pkg::IDX_W-1:0]     wr_addr;
  logic [can_rmt_pkg::IDX_W-1:0]     rd_addr;
  logic                              rd_en;
  logic [can_rmt_pkg::PAYLOAD_W-1:0] wr_payload;
  logic [can_rmt_pkg::COUNT_W-1:0]   wr_count;
  logic [can_rmt_pkg::COUNT_W-1:0]   hit_count;
  logic                              ident_eq;
  logic                              hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      mux_ident <= can_rmt_pkg::MUX_IDENT_RESET;
      entries_in_use <= '0;
    end else if (cfg_write) begin
      case (can_rmt_pkg::reg_index_t'(cfg_index))
        can_rmt_pkg::REG_MUX_IDENT:      mux_ident <= cfg_data;
        can_rmt_pkg::REG_ENTRIES_IN_USE: entries_in_use <= cfg_data[can_rmt_pkg::LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_ident <= ident;
      item_ext <= extended;
      item_payload <= payload;
      item_slot <= slot;
      item_sub <= sub_register;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_idx <= '0;
      cmp_valid <= 1'b0;
    end else begin
      cmp_valid <= cmd.read_scan;
      if (cmd.capture) begin
        scan_idx <= '0;
      end else if (cmd.read_scan) begin
        scan_idx <= scan_idx + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.read_scan) begin
      cmp_idx <= scan_idx[can_rmt_pkg::IDX_W-1:0];
    end
  end

  // Saturate the search length at the table size.
  assign limit = (32'(entries_in_use) > N) ? can_rmt_pkg::CNT_W'(N)
                                           : can_rmt_pkg::CNT_W'(entries_in_use);
  assign item_idx = can_rmt_pkg::IDX_W'(item_slot);
  assign slot_ok = 32'(item_slot) < N;
  assign load_en = cmd.load && slot_ok;

  assign ident_eq = rd_ident == item_ident;
  assign hit = cmp_valid && ident_eq &&
               ((item_ident == mux_ident) ? (rd_sub == item_payload[can_rmt_pkg::SUB_W-1:0])
                                          : (rd_type == item_ext));
  assign status.hit = hit;
  assign status.scan_more = scan_idx < limit;

  assign hit_count = (valid[cmp_idx] ? rd_count : '0) + 1'b1;
  assign wr_en = load_en || cmd.update;
  assign wr_addr = cmd.load ? item_idx : cmp_idx;
  assign wr_payload = cmd.load ? '0 : item_payload;
  assign wr_count = cmd.load ? '0 : hit_count;
  assign rd_en = cmd.read_scan || cmd.read_slot;
  assign rd_addr = cmd.read_scan ? scan_idx[can_rmt_pkg::IDX_W-1:0] : item_idx;

  always_ff @(posedge clk) begin
    if (load_en) begin
      mem_ident[item_idx] <= item_ident;
      mem_type[item_idx] <= item_ext;
      mem_sub[item_idx] <= item_sub;
    end
    if (rd_en) begin
      rd_ident <= mem_ident[rd_addr];
      rd_type <= mem_type[rd_addr];
      rd_sub <= mem_sub[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_payload[wr_addr] <= wr_payload;
      mem_count[wr_addr] <= wr_count;
    end
    if (rd_en) begin
      rd_payload <= mem_payload[rd_addr];
      rd_count <= mem_count[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      fresh <= '0;
    end else if (wr_en) begin
      valid[wr_addr] <= 1'b1;
      fresh[wr_addr] <= cmd.update;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.result != can_rmt_pkg::RES_NONE;
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.result)
      can_rmt_pkg::RES_FRAME: begin
        matched <= hit;
        match_slot <= hit ? can_rmt_pkg::SLOT_W'(cmp_idx) : '0;
        read_ident <= '0;
        read_extended <= 1'b0;
        read_sub_register <= '0;
        read_payload <= '0;
        read_fresh <= 1'b0;
        read_count <= '0;
      end
      can_rmt_pkg::RES_LOAD: begin
        matched <= slot_ok;
        match_slot <= slot_ok ? item_slot : '0;
        read_ident <= '0;
        read_extended <= 1'b0;
        read_sub_register <= '0;
        read_payload <= '0;
        read_fresh <= 1'b0;
        read_count <= '0;
      end
      can_rmt_pkg::RES_READ: begin
        matched <= slot_ok;
        match_slot <= slot_ok ? item_slot : '0;
        read_ident <= slot_ok ? rd_ident : '0;
        read_extended <= slot_ok && rd_type;
        read_sub_register <= slot_ok ? rd_sub : '0;
        read_payload <= (slot_ok && valid[item_idx]) ? rd_payload : '0;
        read_fresh <= slot_ok && fresh[item_idx];
        read_count <= (slot_ok && valid[item_idx]) ? rd_count : '0;
      end
      can_rmt_pkg::RES_ZERO: begin
        matched <= 1'b0;
        match_slot <= '0;
        read_ident <= '0;
        read_extended <= 1'b0;
        read_sub_register <= '0;
        read_payload <= '0;
        read_fresh <= 1'b0;
        read_count <= '0;
      end
      default: ;
    endcase
  end

endmodule

@@ rtl/can_receive_message_table.sv @@
// Top level of the CAN receive message table: sequencer plus entry datapath.
//
// The block keeps sixteen entries of expected CAN frames and takes one request
// at a time: start is honored when busy is low. A received frame (kind 0) walks
// the entries from zero up to entries_in_use (saturated at sixteen), one entry
// fetched per cycle from the entry store while the entry fetched the cycle before
// is compared; the first hit stores the payload, sets fresh and bumps the count
// in that same cycle and stops the walk. The entry store has a single read port. A
// load writes the slot in its load state, a read fetches the slot and then picks its
// result, and an unknown kind returns zeros. The next request can be accepted in
// the cycle that done is high. Results show for exactly one cycle with done and
// cannot be held off, so the receiver must take them as they come. No clearing
// pass is needed after reset: per-entry valid bits make unloaded entries read with
// zero payload and count. The user must write configuration through cfg_write,
// cfg_index and cfg_data only while the block is idle; the block does not enforce it.
module can_receive_message_table (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [can_rmt_pkg::KIND_W-1:0]       kind,
  input  logic [can_rmt_pkg::IDENT_W-1:0]      ident,
  input  logic                                 extended,
  input  logic [can_rmt_pkg::PAYLOAD_W-1:0]    payload,
  input  logic [can_rmt_pkg::SLOT_W-1:0]       slot,
  input  logic [can_rmt_pkg::SUB_W-1:0]        sub_register,
  input  logic                                 cfg_write,
  input  logic [can_rmt_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [can_rmt_pkg::CFG_DATA_W-1:0]   cfg_data,
  output logic                                 done,
  output logic                                 matched,
  output logic [can_rmt_pkg::SLOT_W-1:0]       match_slot,
  output logic [can_rmt_pkg::IDENT_W-1:0]      read_ident,
  output logic                                 read_extended,
  output logic [can_rmt_pkg::SUB_W-1:0]        read_sub_register,
  output logic [can_rmt_pkg::PAYLOAD_W-1:0]    read_payload,
  output logic                                 read_fresh,
  output logic [can_rmt_pkg::COUNT_W-1:0]      read_count
);

  can_rmt_pkg::cmd_t    cmd;
  can_rmt_pkg::status_t status;

  // Sequence each request: decode kind, walk entries, pick the result.
  can_rmt_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .kind   (kind),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  // Hold the config registers, entry store and the registered result.
  can_rmt_dp u_dp (
    .clk               (clk),
    .rst               (rst),
    .cfg_write         (cfg_write),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .ident             (ident),
    .extended          (extended),
    .payload           (payload),
    .slot              (slot),
    .sub_register      (sub_register),
    .cmd               (cmd),
    .status            (status),
    .done              (done),
    .matched           (matched),
    .match_slot        (match_slot),
    .read_ident        (read_ident),
    .read_extended     (read_extended),
    .read_sub_register (read_sub_register),
    .read_payload      (read_payload),
    .read_fresh        (read_fresh),
    .read_count        (read_count)
  );

`ifndef SYNTHESIS
  a_accept_goes_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted request did not make the block busy");

  a_done_follows_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result strobe without a request in progress");

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe on two cycles in a row");

  a_miss_slot_zero: assert property (@(posedge clk) disable iff (rst)
    done && !matched |-> match_slot == '0)
    else $error("slot reported without a match");
`endif

endmodule
